@@ src/jsvb_pkg.sv @@
// ----------------------------------------------------------------------------
// jsvb_pkg
// Shared constants and types of the joint safe velocity bounds unit: default
// widths, configuration register indexes and the divider status flags.
// ----------------------------------------------------------------------------
`default_nettype none

package jsvb_pkg;

    // default data format, signed Q8.24 in 32 bits
    localparam int DATA_WIDTH_DEF    = 32;
    localparam int FRACTION_BITS_DEF = 24;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_POS_UPPER = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_POS_LOWER = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VEL_LIMIT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ACC_LIMIT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_JERK      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TIME_STEP = 3'd5;

    // status of one scaled-ratio division
    typedef struct packed {
        logic neg;  // quotient is negative
        logic ovf;  // quotient magnitude beyond the data range
    } div_flag_t;

endpackage

`default_nettype wire

@@ src/joint_safe_velocity_bounds_unit.sv @@
// ----------------------------------------------------------------------------
// joint_safe_velocity_bounds_unit
// Safe lower and upper next velocity of one joint from its last commanded
// position, velocity and acceleration, under position, velocity,
// acceleration and jerk limits. Signed fixed point, saturating.
//
//   channel  direction  contents
//   cfg      in         register index and write data, always ready
//   s_       in         last position, velocity, acceleration
//   m_       out        lower and upper safe velocity
//
// One item enters per cycle while the pipeline is not frozen; the four restoring
// dividers between the front and back stages resolve one quotient bit a stage.
// Reset clears every valid bit and loads the register defaults.
// A result held at m_ with m_tready low freezes the whole pipeline and drops
// s_tready in the same cycle; nothing in flight is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module joint_safe_velocity_bounds_unit #(
    parameter  int DATA_WIDTH    = jsvb_pkg::DATA_WIDTH_DEF,
    parameter  int FRACTION_BITS = jsvb_pkg::FRACTION_BITS_DEF,
    localparam int CFG_W         = (DATA_WIDTH > FRACTION_BITS+1) ? DATA_WIDTH
                                                                  : FRACTION_BITS+1,
    localparam int S_TDATA_W     = ((3*DATA_WIDTH+7)/8)*8,
    localparam int M_TDATA_W     = ((2*DATA_WIDTH+7)/8)*8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [jsvb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]                 cfg_data,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // last_position, last_velocity, last_acceleration
    input  logic [S_TDATA_W-1:0]             s_tdata,
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // lower_safe_velocity, upper_safe_velocity
    output logic [M_TDATA_W-1:0]             m_tdata
);

    import jsvb_pkg::*;

    localparam int N = DATA_WIDTH;
    localparam int F = FRACTION_BITS;
    localparam logic [N-1:0] ONE_N  = {{(N-1){1'b0}}, 1'b1} << F;
    localparam logic [F:0]   DT_RST = (F+1)'((64'd1 << F) / 1000);

    // configuration registers
    logic signed [N-1:0] pos_upper_reg, pos_lower_reg;
    logic        [N-2:0] vel_limit_reg, acc_limit_reg, jerk_reg;
    logic        [F:0]   time_step_reg;
    logic        [N-2:0] vmax_eff, amax_eff;

    // pipeline control
    logic adv;

    // front to dividers
    logic                  front_valid;
    logic signed [2*N-1:0] num_hi, num_lo, num_rlo, num_rhi;
    logic signed [N-1:0]   front_vel, front_aup, front_adn;

    // dividers and side line to back
    logic [N-2:0] quo_hi, quo_lo, quo_rlo, quo_rhi;
    div_flag_t    flag_hi, flag_lo, flag_rlo, flag_rhi;
    logic         side_valid;
    logic [3*N-1:0] side_data;

    logic signed [N-1:0] lower, upper;

    // register writes, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_upper_reg <= ONE_N;
            pos_lower_reg <= -ONE_N;
            vel_limit_reg <= ONE_N[N-2:0];
            acc_limit_reg <= ONE_N[N-2:0];
            jerk_reg      <= ONE_N[N-2:0];
            time_step_reg <= DT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_POS_UPPER: pos_upper_reg <= cfg_data[N-1:0];
                REG_POS_LOWER: pos_lower_reg <= cfg_data[N-1:0];
                REG_VEL_LIMIT: vel_limit_reg <= cfg_data[N-2:0];
                REG_ACC_LIMIT: acc_limit_reg <= cfg_data[N-2:0];
                REG_JERK:      jerk_reg      <= cfg_data[N-2:0];
                REG_TIME_STEP: time_step_reg <= cfg_data[F:0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // a zero limit acts as one lsb
    assign vmax_eff = (vel_limit_reg == '0) ? (N-1)'(1) : vel_limit_reg;
    assign amax_eff = (acc_limit_reg == '0) ? (N-1)'(1) : acc_limit_reg;

    // global advance: stall only while the output register holds a result not taken
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    jsvb_front #(
        .DATA_WIDTH    (N),
        .FRACTION_BITS (F)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_tvalid),
        .in_pos    (s_tdata[N-1:0]),
        .in_vel    (s_tdata[2*N-1:N]),
        .in_acc    (s_tdata[3*N-1:2*N]),
        .pos_upper (pos_upper_reg),
        .pos_lower (pos_lower_reg),
        .vmax      (vmax_eff),
        .amax      (amax_eff),
        .jerk      (jerk_reg),
        .dt        (time_step_reg),
        .out_valid (front_valid),
        .num_hi    (num_hi),
        .num_lo    (num_lo),
        .num_rlo   (num_rlo),
        .num_rhi   (num_rhi),
        .vel       (front_vel),
        .aup       (front_aup),
        .adn       (front_adn)
    );

    // jerk ramp toward the upper velocity limit
    jsvb_div #(.DATA_WIDTH(N)) u_div_hi (
        .aclk     (aclk),
        .en       (adv),
        .dividend (num_hi),
        .divisor  (amax_eff),
        .quo      (quo_hi),
        .flags    (flag_hi)
    );

    // jerk ramp toward the lower velocity limit
    jsvb_div #(.DATA_WIDTH(N)) u_div_lo (
        .aclk     (aclk),
        .en       (adv),
        .dividend (num_lo),
        .divisor  (amax_eff),
        .quo      (quo_lo),
        .flags    (flag_lo)
    );

    // braking ramp to the lower position limit
    jsvb_div #(.DATA_WIDTH(N)) u_div_rlo (
        .aclk     (aclk),
        .en       (adv),
        .dividend (num_rlo),
        .divisor  (vmax_eff),
        .quo      (quo_rlo),
        .flags    (flag_rlo)
    );

    // braking ramp to the upper position limit
    jsvb_div #(.DATA_WIDTH(N)) u_div_rhi (
        .aclk     (aclk),
        .en       (adv),
        .dividend (num_rhi),
        .divisor  (vmax_eff),
        .quo      (quo_rhi),
        .flags    (flag_rhi)
    );

    // velocity and acceleration window alongside the dividers
    jsvb_delay #(
        .WIDTH (3*N),
        .DEPTH (N)
    ) u_side (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (front_valid),
        .in_data   ({front_adn, front_aup, front_vel}),
        .out_valid (side_valid),
        .out_data  (side_data)
    );

    jsvb_back #(
        .DATA_WIDTH    (N),
        .FRACTION_BITS (F)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (side_valid),
        .quo_hi    (quo_hi),
        .quo_lo    (quo_lo),
        .quo_rlo   (quo_rlo),
        .quo_rhi   (quo_rhi),
        .flag_hi   (flag_hi),
        .flag_lo   (flag_lo),
        .flag_rlo  (flag_rlo),
        .flag_rhi  (flag_rhi),
        .vel       (side_data[N-1:0]),
        .aup       (side_data[2*N-1:N]),
        .adn       (side_data[3*N-1:2*N]),
        .amax      (amax_eff),
        .dt        (time_step_reg),
        .out_valid (m_tvalid),
        .lower     (lower),
        .upper     (upper)
    );

    assign m_tdata = M_TDATA_W'({upper, lower});

endmodule

`default_nettype wire

@@ src/jsvb_front.sv @@
// ----------------------------------------------------------------------------
// jsvb_front
// Front stages: input register with limit differences and jerk times time
// step, the four scaled-ratio numerator products, then the acceleration
// window a +/- jerk*dt.
// ----------------------------------------------------------------------------
`default_nettype none

module jsvb_front #(
    parameter int DATA_WIDTH    = jsvb_pkg::DATA_WIDTH_DEF,
    parameter int FRACTION_BITS = jsvb_pkg::FRACTION_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic signed [DATA_WIDTH-1:0]   in_pos,
    input  logic signed [DATA_WIDTH-1:0]   in_vel,
    input  logic signed [DATA_WIDTH-1:0]   in_acc,
    input  logic signed [DATA_WIDTH-1:0]   pos_upper,
    input  logic signed [DATA_WIDTH-1:0]   pos_lower,
    input  logic        [DATA_WIDTH-2:0]   vmax,
    input  logic        [DATA_WIDTH-2:0]   amax,
    input  logic        [DATA_WIDTH-2:0]   jerk,
    input  logic        [FRACTION_BITS:0]  dt,
    output logic                           out_valid,
    output logic signed [2*DATA_WIDTH-1:0] num_hi,
    output logic signed [2*DATA_WIDTH-1:0] num_lo,
    output logic signed [2*DATA_WIDTH-1:0] num_rlo,
    output logic signed [2*DATA_WIDTH-1:0] num_rhi,
    output logic signed [DATA_WIDTH-1:0]   vel,
    output logic signed [DATA_WIDTH-1:0]   aup,
    output logic signed [DATA_WIDTH-1:0]   adn
);

    localparam int N = DATA_WIDTH;
    localparam int F = FRACTION_BITS;
    localparam logic signed [N-1:0] TOP = {1'b0, {(N-1){1'b1}}};
    localparam logic signed [N-1:0] BOT = {1'b1, {(N-1){1'b0}}};

    // clamp a one-bit-grown sum to the data range
    function automatic logic signed [N-1:0] sat_narrow(input logic signed [N:0] x);
        if (x[N] != x[N-1]) begin
            return x[N] ? BOT : TOP;
        end
        return x[N-1:0];
    endfunction

    // stage 1 registers
    logic                  v1_reg;
    logic signed [N-1:0]   dv_hi_reg, dv_lo_reg, dp_lo_reg, dp_hi_reg;
    logic signed [N-1:0]   dv_hi_next, dv_lo_next, dp_lo_next, dp_hi_next;
    logic        [N+F-1:0] jdt_raw_reg, jdt_raw_next;
    logic signed [N-1:0]   vel1_reg, acc1_reg;

    // stage 2 registers
    logic                    v2_reg;
    logic signed [2*N-1:0]   nhi2_reg, nlo2_reg, nrlo2_reg, nrhi2_reg;
    logic signed [2*N-1:0]   nhi2_next, nlo2_next, nrlo2_next, nrhi2_next;
    logic signed [N-1:0]     jdt2_reg, jdt2_next;
    logic signed [N-1:0]     vel2_reg, acc2_reg;
    logic        [N-1:0]     jdt_hi;

    // stage 3 registers
    logic                    v3_reg;
    logic signed [2*N-1:0]   nhi3_reg, nlo3_reg, nrlo3_reg, nrhi3_reg;
    logic signed [N-1:0]     vel3_reg, aup3_reg, adn3_reg;
    logic signed [N-1:0]     aup3_next, adn3_next;

    // differences toward the limits and jerk times time step
    always_comb begin
        dv_hi_next = sat_narrow($signed({2'b00, vmax}) - $signed({in_vel[N-1], in_vel}));
        dv_lo_next = sat_narrow(-$signed({2'b00, vmax}) - $signed({in_vel[N-1], in_vel}));
        dp_lo_next = sat_narrow($signed({pos_lower[N-1], pos_lower})
                                - $signed({in_pos[N-1], in_pos}));
        dp_hi_next = sat_narrow($signed({pos_upper[N-1], pos_upper})
                                - $signed({in_pos[N-1], in_pos}));
        jdt_raw_next = (N+F)'(jerk) * (N+F)'(dt);
    end

    // numerator products and fixed-point jerk step
    always_comb begin
        nhi2_next  = $signed({1'b0, jerk}) * dv_hi_reg;
        nlo2_next  = $signed({1'b0, jerk}) * dv_lo_reg;
        nrlo2_next = $signed({1'b0, amax}) * dp_lo_reg;
        nrhi2_next = $signed({1'b0, amax}) * dp_hi_reg;
        jdt_hi     = jdt_raw_reg[N+F-1:F];
        jdt2_next  = jdt_hi[N-1] ? TOP : $signed(jdt_hi);
    end

    // acceleration window
    always_comb begin
        aup3_next = sat_narrow($signed({acc2_reg[N-1], acc2_reg})
                               + $signed({jdt2_reg[N-1], jdt2_reg}));
        adn3_next = sat_narrow($signed({acc2_reg[N-1], acc2_reg})
                               - $signed({jdt2_reg[N-1], jdt2_reg}));
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        if (en) begin
            dv_hi_reg   <= dv_hi_next;
            dv_lo_reg   <= dv_lo_next;
            dp_lo_reg   <= dp_lo_next;
            dp_hi_reg   <= dp_hi_next;
            jdt_raw_reg <= jdt_raw_next;
            vel1_reg    <= in_vel;
            acc1_reg    <= in_acc;

            nhi2_reg    <= nhi2_next;
            nlo2_reg    <= nlo2_next;
            nrlo2_reg   <= nrlo2_next;
            nrhi2_reg   <= nrhi2_next;
            jdt2_reg    <= jdt2_next;
            vel2_reg    <= vel1_reg;
            acc2_reg    <= acc1_reg;

            nhi3_reg    <= nhi2_reg;
            nlo3_reg    <= nlo2_reg;
            nrlo3_reg   <= nrlo2_reg;
            nrhi3_reg   <= nrhi2_reg;
            vel3_reg    <= vel2_reg;
            aup3_reg    <= aup3_next;
            adn3_reg    <= adn3_next;
        end
    end

    assign out_valid = v3_reg;
    assign num_hi    = nhi3_reg;
    assign num_lo    = nlo3_reg;
    assign num_rlo   = nrlo3_reg;
    assign num_rhi   = nrhi3_reg;
    assign vel       = vel3_reg;
    assign aup       = aup3_reg;
    assign adn       = adn3_reg;

endmodule

`default_nettype wire

@@ src/jsvb_div.sv @@
// ----------------------------------------------------------------------------
// jsvb_div
// Pipelined restoring divider for the scaled ratios: a magnitude stage, then
// one quotient bit per stage. The quotient is kept to DATA_WIDTH-1 bits; a
// larger one is flagged as overflow for saturation downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module jsvb_div #(
    parameter int DATA_WIDTH = jsvb_pkg::DATA_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           en,
    input  logic signed [2*DATA_WIDTH-1:0] dividend,
    input  logic        [DATA_WIDTH-2:0]   divisor,
    output logic        [DATA_WIDTH-2:0]   quo,
    output jsvb_pkg::div_flag_t            flags
);

    import jsvb_pkg::*;

    localparam int N  = DATA_WIDTH;
    localparam int WW = 2*N-2;

    // w holds partial remainder over the dividend bits still to be consumed
    logic [WW-1:0]   w_reg    [N];
    logic [WW-1:0]   w_next   [N];
    logic            neg_reg  [N];
    logic            ovf_reg  [1:N-1];
    logic            ovf_next [1:N-1];
    logic [2*N-1:0]  mag;

    // magnitude of the signed product, then one restoring step per stage
    always_comb begin
        logic [N-1:0] t;
        logic         ge;
        mag         = dividend[2*N-1] ? (2*N)'(-dividend) : (2*N)'(dividend);
        w_next[0]   = mag[WW-1:0];
        ovf_next[1] = (w_reg[0][WW-1:N-1] >= divisor);
        for (int k = 1; k < N; k++) begin
            t         = w_reg[k-1][WW-1:N-2];
            ge        = (t >= {1'b0, divisor});
            t         = ge ? (t - {1'b0, divisor}) : t;
            w_next[k] = {t[N-2:0], w_reg[k-1][N-3:0], ge};
        end
        for (int k = 2; k < N; k++) begin
            ovf_next[k] = ovf_reg[k-1];
        end
    end

    // stage registers
    always_ff @(posedge aclk) begin
        if (en) begin
            w_reg[0]   <= w_next[0];
            neg_reg[0] <= dividend[2*N-1];
            for (int k = 1; k < N; k++) begin
                w_reg[k]   <= w_next[k];
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_next[k];
            end
        end
    end

    assign quo   = w_reg[N-1][N-2:0];
    assign flags = '{neg: neg_reg[N-1], ovf: ovf_reg[N-1]};

endmodule

`default_nettype wire

@@ src/jsvb_delay.sv @@
// ----------------------------------------------------------------------------
// jsvb_delay
// Delay line with valid bits that keeps side data aligned with the dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module jsvb_delay #(
    parameter int WIDTH = 3*jsvb_pkg::DATA_WIDTH_DEF,
    parameter int DEPTH = jsvb_pkg::DATA_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    output logic [WIDTH-1:0] out_data
);

    logic             valid_reg [DEPTH];
    logic [WIDTH-1:0] data_reg  [DEPTH];

    // valid taps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DEPTH; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < DEPTH; k++) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // data taps
    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg[0] <= in_data;
            for (int k = 1; k < DEPTH; k++) begin
                data_reg[k] <= data_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[DEPTH-1];
    assign out_data  = data_reg[DEPTH-1];

endmodule

`default_nettype wire

@@ src/jsvb_back.sv @@
// ----------------------------------------------------------------------------
// jsvb_back
// Back stages: signed saturation of the quotients, acceleration clamp,
// acceleration times time step, velocity bounds and the braking ramp clamp
// into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module jsvb_back #(
    parameter int DATA_WIDTH    = jsvb_pkg::DATA_WIDTH_DEF,
    parameter int FRACTION_BITS = jsvb_pkg::FRACTION_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic        [DATA_WIDTH-2:0]  quo_hi,
    input  logic        [DATA_WIDTH-2:0]  quo_lo,
    input  logic        [DATA_WIDTH-2:0]  quo_rlo,
    input  logic        [DATA_WIDTH-2:0]  quo_rhi,
    input  jsvb_pkg::div_flag_t           flag_hi,
    input  jsvb_pkg::div_flag_t           flag_lo,
    input  jsvb_pkg::div_flag_t           flag_rlo,
    input  jsvb_pkg::div_flag_t           flag_rhi,
    input  logic signed [DATA_WIDTH-1:0]  vel,
    input  logic signed [DATA_WIDTH-1:0]  aup,
    input  logic signed [DATA_WIDTH-1:0]  adn,
    input  logic        [DATA_WIDTH-2:0]  amax,
    input  logic        [FRACTION_BITS:0] dt,
    output logic                          out_valid,
    output logic signed [DATA_WIDTH-1:0]  lower,
    output logic signed [DATA_WIDTH-1:0]  upper
);

    import jsvb_pkg::*;

    localparam int N = DATA_WIDTH;
    localparam int F = FRACTION_BITS;
    localparam int P = N+F+1;
    localparam logic signed [N-1:0] TOP  = {1'b0, {(N-1){1'b1}}};
    localparam logic signed [N-1:0] BOT  = {1'b1, {(N-1){1'b0}}};
    localparam logic signed [P-1:0] BIAS = {{(P-F){1'b0}}, {F{1'b1}}};

    function automatic logic signed [N-1:0] sat_narrow(input logic signed [N:0] x);
        if (x[N] != x[N-1]) begin
            return x[N] ? BOT : TOP;
        end
        return x[N-1:0];
    endfunction

    function automatic logic signed [N-1:0] smin(input logic signed [N-1:0] x,
                                                 input logic signed [N-1:0] y);
        return (x < y) ? x : y;
    endfunction

    function automatic logic signed [N-1:0] smax(input logic signed [N-1:0] x,
                                                 input logic signed [N-1:0] y);
        return (x > y) ? x : y;
    endfunction

    // apply sign and saturation to a quotient magnitude
    function automatic logic signed [N-1:0] fix_quo(input logic [N-2:0] q,
                                                    input div_flag_t  fl);
        if (fl.ovf) begin
            return fl.neg ? BOT : TOP;
        end
        return fl.neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    // truncate a product toward zero by the fraction bits, then saturate
    function automatic logic signed [N-1:0] trunc_frac(input logic signed [P-1:0] x);
        logic signed [P-1:0] b;
        b = x + (x[P-1] ? BIAS : '0);
        b = b >>> F;
        return sat_narrow($signed(b[N:0]));
    endfunction

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    // stage 1: signed ratios
    logic signed [N-1:0] qhi1_reg, qlo1_reg, rlo1_reg, rhi1_reg;
    logic signed [N-1:0] vel1_reg, aup1_reg, adn1_reg;

    // stage 2: clamped accelerations
    logic signed [N-1:0] amx2_reg, amn2_reg, amx2_next, amn2_next;
    logic signed [N-1:0] rlo2_reg, rhi2_reg, vel2_reg;
    logic signed [N-1:0] amax_s;

    // stage 3: acceleration times time step
    logic signed [P-1:0] phi3_reg, plo3_reg, phi3_next, plo3_next;
    logic signed [N-1:0] rlo3_reg, rhi3_reg, vel3_reg;

    // stage 4: velocity steps
    logic signed [N-1:0] dhi4_reg, dlo4_reg;
    logic signed [N-1:0] rlo4_reg, rhi4_reg, vel4_reg;

    // stage 5: velocity bounds
    logic signed [N-1:0] vhi5_reg, vlo5_reg, vhi5_next, vlo5_next;
    logic signed [N-1:0] rlo5_reg, rhi5_reg;

    // stage 6: output register
    logic signed [N-1:0] lower6_reg, upper6_reg, lower6_next, upper6_next;

    // acceleration clamp
    always_comb begin
        amax_s    = $signed({1'b0, amax});
        amx2_next = smax(smin(smin(qhi1_reg, amax_s), aup1_reg), adn1_reg);
        amn2_next = smin(smax(smax(qlo1_reg, -amax_s), adn1_reg), aup1_reg);
    end

    // products with the time step
    always_comb begin
        phi3_next = amx2_reg * $signed({1'b0, dt});
        plo3_next = amn2_reg * $signed({1'b0, dt});
    end

    // velocity bounds from the clamped accelerations
    always_comb begin
        vhi5_next = sat_narrow($signed({vel4_reg[N-1], vel4_reg})
                               + $signed({dhi4_reg[N-1], dhi4_reg}));
        vlo5_next = sat_narrow($signed({vel4_reg[N-1], vel4_reg})
                               + $signed({dlo4_reg[N-1], dlo4_reg}));
    end

    // braking ramp toward the position limits
    always_comb begin
        lower6_next = smin(smax(vlo5_reg, rlo5_reg), vhi5_reg);
        upper6_next = smax(smin(vhi5_reg, rhi5_reg), vlo5_reg);
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        if (en) begin
            qhi1_reg   <= fix_quo(quo_hi, flag_hi);
            qlo1_reg   <= fix_quo(quo_lo, flag_lo);
            rlo1_reg   <= fix_quo(quo_rlo, flag_rlo);
            rhi1_reg   <= fix_quo(quo_rhi, flag_rhi);
            vel1_reg   <= vel;
            aup1_reg   <= aup;
            adn1_reg   <= adn;

            amx2_reg   <= amx2_next;
            amn2_reg   <= amn2_next;
            rlo2_reg   <= rlo1_reg;
            rhi2_reg   <= rhi1_reg;
            vel2_reg   <= vel1_reg;

            phi3_reg   <= phi3_next;
            plo3_reg   <= plo3_next;
            rlo3_reg   <= rlo2_reg;
            rhi3_reg   <= rhi2_reg;
            vel3_reg   <= vel2_reg;

            dhi4_reg   <= trunc_frac(phi3_reg);
            dlo4_reg   <= trunc_frac(plo3_reg);
            rlo4_reg   <= rlo3_reg;
            rhi4_reg   <= rhi3_reg;
            vel4_reg   <= vel3_reg;

            vhi5_reg   <= vhi5_next;
            vlo5_reg   <= vlo5_next;
            rlo5_reg   <= rlo4_reg;
            rhi5_reg   <= rhi4_reg;

            lower6_reg <= lower6_next;
            upper6_reg <= upper6_next;
        end
    end

    assign out_valid = v6_reg;
    assign lower     = lower6_reg;
    assign upper     = upper6_reg;

endmodule

`default_nettype wire

@@ src/jsvb_checker.sv @@
// ----------------------------------------------------------------------------
// jsvb_checker
// Port-level checks of the safe velocity bounds unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module jsvb_checker #(
    parameter int M_TDATA_W = 2*jsvb_pkg::DATA_WIDTH_DEF
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // a stalled result keeps its data
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a held result stalls the input side
    a_stall_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while the pipeline is frozen");

    // a free output lets the input side take a transfer
    a_free_input: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with the output register empty");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result present after reset");

endmodule

bind joint_safe_velocity_bounds_unit jsvb_checker #(
    .M_TDATA_W (M_TDATA_W)
) u_jsvb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ tb/joint_safe_velocity_bounds_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_safe_velocity_bounds_unit_test
// Self-checking bench for the joint safe velocity bounds unit. Position,
// velocity and acceleration transfers go in through the s_ stream in random
// bursts, and the m_ stream is stalled on a changing pattern. A scoreboard
// computes the expected lower and upper bound of every accepted transfer and
// checks each result in order. The limit registers are rewritten between
// phases, once the pipeline has drained: zero, one-LSB, full-scale, inverted
// and random limits are all visited.
// ----------------------------------------------------------------------------

module joint_safe_velocity_bounds_unit_test;

    import jsvb_pkg::*;

    localparam int     DW           = 32;
    localparam longint Q_MAX        = 64'sh0000_0000_7fff_ffff;
    localparam longint Q_MIN        = -Q_MAX - 1;
    localparam longint Q_ONE        = 64'sd16777216;
    localparam int     DRAIN_CYCLES = 48;
    localparam int     STALL_LIMIT  = 4000;
    localparam int     PHASE_ITEMS  = 200;
    localparam int     PHASES       = 8;

    // register indexes that the block does not decode
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef enum {READY_ALWAYS, READY_MOSTLY, READY_RARELY, READY_PERIODIC} sink_mode_t;

    typedef struct packed {
        logic signed [DW-1:0] upper;
        logic signed [DW-1:0] lower;
    } bounds_t;

    // ------------------------------------------------------------------------
    // expected bounds: own copy of the limits and the bound arithmetic
    // ------------------------------------------------------------------------
    class bounds_scoreboard;
        longint  pos_upper, pos_lower, vel_limit, acc_limit, jerk, dt;
        bounds_t expected_bounds[$];
        int      mismatches;
        int      inputs_noted;
        int      results_checked;

        function new();
            pos_upper = Q_ONE;
            pos_lower = -Q_ONE;
            vel_limit = Q_ONE;
            acc_limit = Q_ONE;
            jerk      = Q_ONE;
            dt        = 16777;
        endfunction

        function longint saturate(longint x);
            if (x > Q_MAX) return Q_MAX;
            if (x < Q_MIN) return Q_MIN;
            return x;
        endfunction

        function longint lesser(longint x, longint y);
            return (x < y) ? x : y;
        endfunction

        function longint greater(longint x, longint y);
            return (x > y) ? x : y;
        endfunction

        // fixed-point product, truncated toward zero
        function longint mul_q(longint x, longint y);
            return saturate((x * y) / Q_ONE);
        endfunction

        function longint muldiv_q(longint x, longint y, longint z);
            return saturate((x * y) / z);
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [DW-1:0] data);
            case (idx)
                REG_POS_UPPER: pos_upper = longint'($signed(data));
                REG_POS_LOWER: pos_lower = longint'($signed(data));
                REG_VEL_LIMIT: vel_limit = longint'(data[30:0]);
                REG_ACC_LIMIT: acc_limit = longint'(data[30:0]);
                REG_JERK:      jerk      = longint'(data[30:0]);
                REG_TIME_STEP: dt        = longint'(data[24:0]);
                default: ;
            endcase
        endfunction

        function void note_input(logic signed [DW-1:0] pos, logic signed [DW-1:0] vel,
                                 logic signed [DW-1:0] acc);
            longint  p, v, a, vmax, amax, jdt, acc_up, acc_dn, acc_hi, acc_lo;
            longint  vel_hi, vel_lo, ramp_lo, ramp_hi;
            bounds_t b;
            p = pos;
            v = vel;
            a = acc;
            // a zero speed or acceleration limit counts as one LSB
            vmax = (vel_limit == 0) ? 1 : vel_limit;
            amax = (acc_limit == 0) ? 1 : acc_limit;
            // acceleration window from jerk and distance to the speed limit
            jdt    = mul_q(jerk, dt);
            acc_up = saturate(a + jdt);
            acc_dn = saturate(a - jdt);
            acc_hi = muldiv_q(jerk, saturate(vmax - v), amax);
            acc_hi = greater(lesser(lesser(acc_hi, amax), acc_up), acc_dn);
            acc_lo = muldiv_q(jerk, saturate(-vmax - v), amax);
            acc_lo = lesser(greater(greater(acc_lo, -amax), acc_dn), acc_up);
            vel_hi = saturate(v + mul_q(acc_hi, dt));
            vel_lo = saturate(v + mul_q(acc_lo, dt));
            // braking ramps toward the position limits
            ramp_lo = muldiv_q(amax, saturate(pos_lower - p), vmax);
            ramp_hi = muldiv_q(amax, saturate(pos_upper - p), vmax);
            b.lower = lesser(greater(vel_lo, ramp_lo), vel_hi);
            b.upper = greater(lesser(vel_hi, ramp_hi), vel_lo);
            expected_bounds.push_back(b);
            inputs_noted++;
        endfunction

        function void check_result(logic signed [DW-1:0] lower, logic signed [DW-1:0] upper);
            bounds_t b;
            if (expected_bounds.size() == 0) begin
                $error("result with nothing expected: lower %0d, upper %0d", lower, upper);
                mismatches++;
                return;
            end
            b = expected_bounds.pop_front();
            results_checked++;
            if (lower !== b.lower) begin
                $error("lower_safe_velocity: expected %0d, got %0d", b.lower, lower);
                mismatches++;
            end
            if (upper !== b.upper) begin
                $error("upper_safe_velocity: expected %0d, got %0d", b.upper, upper);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_bounds.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block and its signals
    // ------------------------------------------------------------------------
    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [DW-1:0]          cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    // last_position, last_velocity, last_acceleration
    logic [3*DW-1:0]        s_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b1;
    // lower_safe_velocity, upper_safe_velocity
    logic [2*DW-1:0]        m_tdata;

    bounds_scoreboard sb = new();
    sink_mode_t       sink_mode = READY_ALWAYS;
    int               sink_timer = 0;
    int               cycle_count = 0;
    int               quiet_cycles = 0;
    int               settings_applied = 0;

    joint_safe_velocity_bounds_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #6 aclk = ~aclk;

    // result sink stalls, switching to a random pattern whenever its timer runs out
    always @(negedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (sink_timer == 0) begin
            sink_mode  <= sink_mode_t'($urandom_range(0, 3));
            sink_timer <= $urandom_range(20, 150);
        end else begin
            sink_timer <= sink_timer - 1;
        end
        case (sink_mode)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
            READY_RARELY: m_tready <= ($urandom_range(0, 3) == 0);
            default:      m_tready <= ((cycle_count % 7) < 4);
        endcase
    end

    // result checking
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[DW-1:0], m_tdata[2*DW-1:DW]);
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic write_limit(input logic [CFG_INDEX_W-1:0] idx, input logic [DW-1:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_register(idx, value);
    endtask

    task automatic apply_limits(input logic [DW-1:0] pu, input logic [DW-1:0] pl,
                                input logic [DW-1:0] vl, input logic [DW-1:0] al,
                                input logic [DW-1:0] jk, input logic [DW-1:0] ts);
        write_limit(REG_POS_UPPER, pu);
        write_limit(REG_POS_LOWER, pl);
        write_limit(REG_VEL_LIMIT, vl);
        write_limit(REG_ACC_LIMIT, al);
        write_limit(REG_JERK, jk);
        write_limit(REG_TIME_STEP, ts);
        @(negedge aclk);
        cfg_valid = 1'b0;
        settings_applied++;
    endtask

    task automatic send_item(input logic signed [DW-1:0] pos, input logic signed [DW-1:0] vel,
                             input logic signed [DW-1:0] acc);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {acc, vel, pos};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(pos, vel, acc);
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (cycles - 1) @(negedge aclk);
        end
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain();
        hold_off(1);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // stimulus values
    // ------------------------------------------------------------------------
    function automatic logic signed [DW-1:0] near(longint centre, longint spread);
        longint offset;
        offset = (spread <= 0) ? 0 : (longint'($urandom) % (2 * spread + 1)) - spread;
        return sb.saturate(centre + offset);
    endfunction

    function automatic logic signed [DW-1:0] extreme_value();
        case ($urandom_range(0, 6))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return 0;
            3:       return -1;
            4:       return 1;
            5:       return Q_ONE;
            default: return -Q_ONE;
        endcase
    endfunction

    task automatic pick_item(output logic signed [DW-1:0] pos, output logic signed [DW-1:0] vel,
                             output logic signed [DW-1:0] acc);
        longint vmax, amax, span;
        vmax = (sb.vel_limit == 0) ? 1 : sb.vel_limit;
        amax = (sb.acc_limit == 0) ? 1 : sb.acc_limit;
        case ($urandom_range(0, 9))
            // operating point inside or just past the limits
            0, 1, 2, 3, 4, 5: begin
                span = sb.pos_upper - sb.pos_lower;
                if (span < 0) span = -span;
                case ($urandom_range(0, 2))
                    0:       pos = near(sb.pos_upper, span / 8 + 16);
                    1:       pos = near(sb.pos_lower, span / 8 + 16);
                    default: pos = near((sb.pos_upper + sb.pos_lower) / 2, span / 2 + 16);
                endcase
                vel = near(0, vmax + vmax / 4);
                acc = near(0, amax + amax / 4);
            end
            6, 7: begin
                pos = $urandom;
                vel = $urandom;
                acc = $urandom;
            end
            8: begin
                pos = extreme_value();
                vel = extreme_value();
                acc = extreme_value();
            end
            // exactly on a limit
            default: begin
                pos = $urandom_range(0, 1) ? sb.pos_upper : sb.pos_lower;
                vel = $urandom_range(0, 1) ? vmax : -vmax;
                acc = $urandom_range(0, 1) ? amax : -amax;
            end
        endcase
    endtask

    task automatic send_phase(input int count);
        logic signed [DW-1:0] pos, vel, acc;
        int                   sent, burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 48);
            for (int k = 0; k < burst && sent < count; k++) begin
                pick_item(pos, vel, acc);
                send_item(pos, vel, acc);
                sent++;
            end
            case ($urandom_range(0, 4))
                0, 1:    hold_off(0);
                2, 3:    hold_off($urandom_range(1, 4));
                default: hold_off($urandom_range(5, 30));
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: field extremes and limit corners under the reset limits
        send_item(0, 0, 0);
        send_item(Q_MAX, Q_MAX, Q_MAX);
        send_item(Q_MIN, Q_MIN, Q_MIN);
        send_item(Q_MAX, Q_MIN, Q_MAX);
        send_item(Q_MIN, Q_MAX, Q_MIN);
        send_item(-1, -1, -1);
        send_item(1, 1, 1);
        send_item(Q_ONE, Q_ONE, Q_ONE);
        send_item(-Q_ONE, -Q_ONE, -Q_ONE);
        send_item(Q_ONE + Q_ONE / 2, Q_ONE / 2, 0);
        send_item(-Q_ONE - Q_ONE / 2, -Q_ONE / 2, 0);
        send_item(0, 0, Q_ONE / 2);
        send_item(0, Q_ONE - 1, -Q_ONE / 4);
        send_item(Q_ONE - 1, 2 * Q_ONE, 3 * Q_ONE);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                // realistic arm joint, 1 ms period
                0: apply_limits(32'sd48653926, -32'sd48653926, 32'sd43620761,
                                32'sd251658240, 32'sd1677721600, 32'sd16777);
                // slower loop, tight range
                1: apply_limits(Q_ONE / 2, -Q_ONE / 2, Q_ONE, 5 * Q_ONE,
                                20 * Q_ONE, 32'sd167772);
                // zero limits, undecoded indexes alongside
                2: begin
                    write_limit(REG_SPARE_LO, $urandom);
                    write_limit(REG_SPARE_HI, $urandom);
                    apply_limits(0, 0, 0, 0, 0, 1);
                end
                // all ones: full scale after masking
                3: apply_limits(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                                32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
                // lower position limit above the upper one
                4: apply_limits(-Q_ONE / 2, Q_ONE / 2, Q_ONE, 4 * Q_ONE,
                                50 * Q_ONE, 32'sd16777);
                // one-LSB limits
                5: apply_limits(1, -1, 1, 1, 1, 1);
                default: begin
                    write_limit(REG_SPARE_HI, $urandom);
                    apply_limits($urandom, $urandom, $urandom, $urandom, $urandom,
                                 $urandom_range(1, 32'h0100_0000));
                end
            endcase
            send_phase(PHASE_ITEMS);
            drain();
        end

        $display("Run covered %0d input transfers and %0d checked results over %0d limit settings",
                 sb.inputs_noted, sb.results_checked, settings_applied);
        $display("Settings spanned zero, one-LSB, full-scale, inverted and random limits");
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
